[src/rtb_pkg.sv]
// ----------------------------------------------------------------------------
// Repeating timer bank package
// Shared types and codes for the timer bank: opcodes, result status codes,
// the per-slot entry that travels round the ring and the per-step result.
// ----------------------------------------------------------------------------
`default_nettype none

package rtb_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned REPS_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_W    = 16;

  // Opcodes carried by an input transaction.
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_RESET  = 3'd3;
  localparam logic [OP_W-1:0] OP_EXISTS = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST   = 3'd5;

  // Status codes of a result transaction.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FIRED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LISTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTHING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOTIMER = 3'd6;

  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 16'd50;

  // One timer slot as held by a cell.
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] delay;
    logic [REPS_W-1:0] reps;
  } slot_ent_t;

  // Result produced by the head for the slot it is looking at.
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [TIME_W-1:0]   left;
  } step_res_t;

endpackage

`default_nettype wire

[src/rtb_cell.sv]
// ----------------------------------------------------------------------------
// Timer slot cell
// Holds one timer slot and takes its neighbour's slot whenever the ring moves.
// ----------------------------------------------------------------------------
`default_nettype none

module rtb_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 shift_en,
  input  rtb_pkg::slot_ent_t  ent_in,
  output rtb_pkg::slot_ent_t  ent_out
);
  import rtb_pkg::*;

  logic              valid_r;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] delay_r;
  logic [REPS_W-1:0] reps_r;

  // The valid bit is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= ent_in.valid;
    end
  end

  // Timer payload follows the valid bit round the ring.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      start_r <= ent_in.start;
      delay_r <= ent_in.delay;
      reps_r  <= ent_in.reps;
    end
  end

  assign ent_out = '{valid: valid_r, start: start_r, delay: delay_r, reps: reps_r};

endmodule

`default_nettype wire

[src/rtb_head.sv]
// ----------------------------------------------------------------------------
// Timer ring head
// Applies the current operation to the slot at the head of the ring, giving
// the updated slot to write back at the tail and any result it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module rtb_head (
  input  wire  [rtb_pkg::OP_W-1:0]   op,
  input  wire  [rtb_pkg::SLOT_W-1:0] idx,
  input  wire  [rtb_pkg::SLOT_W-1:0] slot,
  input  wire  [rtb_pkg::TIME_W-1:0] now,
  input  wire  [rtb_pkg::TIME_W-1:0] delay_ticks,
  input  wire  [rtb_pkg::REPS_W-1:0] repeat_count,
  input  wire  [rtb_pkg::TIME_W-1:0] threshold,
  input  wire                        too_short,
  input  wire                        alloc_done,
  input  rtb_pkg::slot_ent_t         ent_in,
  output rtb_pkg::slot_ent_t         ent_out,
  output rtb_pkg::step_res_t         res
);
  import rtb_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic [TIME_W-1:0] left;
  logic              match;

  // Wrap-safe elapsed time; an overdue timer has no time left.
  assign elapsed = now - ent_in.start;
  assign due     = (elapsed >= ent_in.delay);
  assign left    = due ? '0 : (ent_in.delay - elapsed);
  assign match   = ent_in.valid && (idx == slot);

  always_comb begin
    ent_out = ent_in;
    res     = '{valid: 1'b0, status: ST_NOTHING, found: 1'b0, left: '0};
    unique case (op)
      OP_TICK: begin
        if (ent_in.valid && due) begin
          res.valid  = 1'b1;
          res.status = ST_FIRED;
          if (ent_in.reps == REPS_W'(1)) begin
            ent_out.valid = 1'b0;
          end else begin
            if (ent_in.reps != '0) begin
              ent_out.reps = ent_in.reps - REPS_W'(1);
            end
            ent_out.start = now;
          end
        end
      end
      OP_ADD: begin
        // Only the lowest free slot is taken.
        if (!ent_in.valid && !alloc_done && !too_short) begin
          ent_out    = '{valid: 1'b1, start: now, delay: delay_ticks, reps: repeat_count};
          res.valid  = 1'b1;
          res.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (match) begin
          ent_out.valid = 1'b0;
          res.valid     = 1'b1;
          res.status    = ST_OK;
        end
      end
      OP_RESET: begin
        if (match) begin
          ent_out.start = now;
          res.valid     = 1'b1;
          res.status    = ST_OK;
        end
      end
      OP_EXISTS: begin
        if (match) begin
          res.valid  = 1'b1;
          res.status = ST_OK;
          res.found  = 1'b1;
        end
      end
      OP_LIST: begin
        if (ent_in.valid && ((threshold == '0) || (left <= threshold))) begin
          res.valid  = 1'b1;
          res.status = ST_LISTED;
          res.left   = left;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[src/repeating_timer_bank.sv]
// ----------------------------------------------------------------------------
// Repeating timer bank
// A bank of NUM_TIMERS repeating timers held in a ring of slot cells.
// ----------------------------------------------------------------------------
// Every command keeps busy high while the slots rotate once round the ring,
// one slot past the head unit per cycle, then a closing cycle. Results
// appear on the out_ ports at most one per cycle with
// out_valid high for exactly one cycle and cannot be held off by the
// receiver. Each result found by the head is held back until the head finds
// the next one, or until the closing cycle, so that the final one can be
// marked, and it is shown in the cycle after that. The final result of a
// command (out_last high) therefore appears in the first idle cycle after
// busy falls, and a new command may be started in that same cycle.
// Configuration writes to min_interval should be made while busy is low.
`default_nettype none

module repeating_timer_bank #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  [rtb_pkg::OP_W-1:0]     in_opcode,
  input  wire  [rtb_pkg::SLOT_W-1:0]   in_slot,
  input  wire  [rtb_pkg::TIME_W-1:0]   in_delay_ticks,
  input  wire  [rtb_pkg::REPS_W-1:0]   in_repeat_count,
  input  wire  [rtb_pkg::TIME_W-1:0]   in_threshold,
  output logic                         out_valid,
  output logic [rtb_pkg::STATUS_W-1:0] out_status,
  output logic [rtb_pkg::SLOT_W-1:0]   out_timer_slot,
  output logic                         out_found,
  output logic [rtb_pkg::TIME_W-1:0]   out_time_left,
  output logic                         out_last,
  input  wire                          cfg_we,
  input  wire  [rtb_pkg::CFG_W-1:0]    cfg_wdata
);
  import rtb_pkg::*;

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [CFG_W-1:0]    min_interval_r;
  logic [TIME_W-1:0]   now_r;

  // Latched command.
  logic [OP_W-1:0]     op_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [TIME_W-1:0]   delay_r;
  logic [REPS_W-1:0]   reps_r;
  logic [TIME_W-1:0]   thr_r;
  logic                short_r;

  // Result held back until the next one, or the end, shows whether it is last.
  logic                pend_valid_r;
  logic [STATUS_W-1:0] pend_status_r;
  logic [SLOT_W-1:0]   pend_slot_r;
  logic                pend_found_r;
  logic [TIME_W-1:0]   pend_left_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_found_r;
  logic [TIME_W-1:0]   out_left_r;
  logic                out_last_r;

  logic                accept;
  logic                shift_en;
  logic                last_step;
  logic [SLOT_W-1:0]   head_idx;
  slot_ent_t           ent      [NUM_TIMERS];
  slot_ent_t           head_out;
  step_res_t           res;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign shift_en  = (state_r == S_SCAN);
  assign last_step = (cnt_r == IDX_W'(NUM_TIMERS - 1));
  assign head_idx  = SLOT_W'(cnt_r);

  // Ring of slot cells: each takes the next one's slot, the tail takes the head's output.
  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    if (k == NUM_TIMERS - 1) begin : g_tail
      rtb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .ent_in   (head_out),
        .ent_out  (ent[k])
      );
    end else begin : g_body
      rtb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .ent_in   (ent[k+1]),
        .ent_out  (ent[k])
      );
    end
  end

  rtb_head u_head (
    .op           (op_r),
    .idx          (head_idx),
    .slot         (slot_r),
    .now          (now_r),
    .delay_ticks  (delay_r),
    .repeat_count (reps_r),
    .threshold    (thr_r),
    .too_short    (short_r),
    .alloc_done   (pend_valid_r),
    .ent_in       (ent[0]),
    .ent_out      (head_out),
    .res          (res)
  );

  // Sequencer: one rotation of the ring, then a closing cycle.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (last_step) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Configuration register and tick counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= MIN_INTERVAL_RST;
      now_r          <= '0;
    end else begin
      if (cfg_we) begin
        min_interval_r <= cfg_wdata;
      end
      if (accept && (in_opcode == OP_TICK)) begin
        now_r <= now_r + TIME_W'(1);
      end
    end
  end

  // Capture the command on an accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      slot_r  <= in_slot;
      delay_r <= in_delay_ticks;
      reps_r  <= in_repeat_count;
      thr_r   <= in_threshold;
      short_r <= (in_delay_ticks < TIME_W'(min_interval_r));
    end
  end

  // Pending result and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (state_r == S_SCAN) begin
        if (res.valid) begin
          pend_valid_r <= 1'b1;
          out_valid_r  <= pend_valid_r;
        end
      end else if (state_r == S_FIN) begin
        pend_valid_r <= 1'b0;
        out_valid_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_SCAN) && res.valid) begin
      pend_status_r <= res.status;
      pend_slot_r   <= head_idx;
      pend_found_r  <= res.found;
      pend_left_r   <= res.left;
      out_status_r  <= pend_status_r;
      out_slot_r    <= pend_slot_r;
      out_found_r   <= pend_found_r;
      out_left_r    <= pend_left_r;
      out_last_r    <= 1'b0;
    end else if (state_r == S_FIN) begin
      out_last_r <= 1'b1;
      if (pend_valid_r) begin
        out_status_r <= pend_status_r;
        out_slot_r   <= pend_slot_r;
        out_found_r  <= pend_found_r;
        out_left_r   <= pend_left_r;
      end else begin
        // No result from the scan: the closing answer depends on the opcode.
        out_found_r <= 1'b0;
        out_left_r  <= '0;
        unique case (op_r)
          OP_ADD: begin
            out_status_r <= short_r ? ST_SHORT : ST_FULL;
            out_slot_r   <= '0;
          end
          OP_REMOVE, OP_RESET: begin
            out_status_r <= ST_NOTIMER;
            out_slot_r   <= slot_r;
          end
          OP_EXISTS: begin
            out_status_r <= ST_OK;
            out_slot_r   <= slot_r;
          end
          default: begin
            out_status_r <= ST_NOTHING;
            out_slot_r   <= '0;
          end
        endcase
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_timer_slot = out_slot_r;
  assign out_found      = out_found_r;
  assign out_time_left  = out_left_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

[src/rtb_checker.sv]
// ----------------------------------------------------------------------------
// Repeating timer bank checker
// Port-level checks of command sequencing and result framing.
// ----------------------------------------------------------------------------
`default_nettype none

module rtb_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          start,
  input wire                          busy,
  input wire                          out_valid,
  input wire [rtb_pkg::STATUS_W-1:0]  out_status,
  input wire                          out_found,
  input wire [rtb_pkg::TIME_W-1:0]    out_time_left,
  input wire                          out_last
);
  import rtb_pkg::*;

  // An accepted transaction makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a command");

  // A new command never shows a result in its first cycle.
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result shown straight after a command was accepted");

  // Intermediate results only occur while the command is still running.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("non-final result seen while idle");

  // The final result comes once the command has finished.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("final result seen while still busy");

  // A firing carries neither a time left nor an exists answer.
  a_fired_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FIRED)) |-> ((out_time_left == '0) && !out_found))
    else $error("fire result carries stray fields");

endmodule

bind repeating_timer_bank rtb_checker u_rtb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_found     (out_found),
  .out_time_left (out_time_left),
  .out_last      (out_last)
);

`default_nettype wire

[bench/timer_bank_checker.sv]
// ----------------------------------------------------------------------------
// Timer bank checker
// Watches the command, result and configuration ports of the timer bank. It
// keeps its own copy of the slot table and tick counter, works out the results
// of each accepted command and compares every result transaction with them.
// ----------------------------------------------------------------------------
module timer_bank_checker #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire                          busy,
  input  wire  [rtb_pkg::OP_W-1:0]     in_opcode,
  input  wire  [rtb_pkg::SLOT_W-1:0]   in_slot,
  input  wire  [rtb_pkg::TIME_W-1:0]   in_delay_ticks,
  input  wire  [rtb_pkg::REPS_W-1:0]   in_repeat_count,
  input  wire  [rtb_pkg::TIME_W-1:0]   in_threshold,
  input  wire                          out_valid,
  input  wire  [rtb_pkg::STATUS_W-1:0] out_status,
  input  wire  [rtb_pkg::SLOT_W-1:0]   out_timer_slot,
  input  wire                          out_found,
  input  wire  [rtb_pkg::TIME_W-1:0]   out_time_left,
  input  wire                          out_last,
  input  wire                          cfg_we,
  input  wire  [rtb_pkg::CFG_W-1:0]    cfg_wdata,
  output int                           mismatches,
  output int                           pending,
  output int                           results_checked,
  output int                           fires_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  import rtb_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                found;
    logic [TIME_W-1:0]   left;
    logic                last;
  } timer_result_t;

  // Results still owed by the bank, oldest first.
  timer_result_t awaited_results[$];

  // Shadow slot table, tick counter and minimum delay.
  bit                slot_live      [NUM_TIMERS];
  logic [TIME_W-1:0] slot_began     [NUM_TIMERS];
  logic [TIME_W-1:0] slot_period    [NUM_TIMERS];
  logic [REPS_W-1:0] slot_reps_left [NUM_TIMERS];
  logic [TIME_W-1:0] tick_count;
  logic [CFG_W-1:0]  shortest_delay;

  int mismatch_total = 0;
  int checked_total  = 0;
  int fire_total     = 0;

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
    fires_seen      = 0;
  end

  function automatic void await_result(logic [STATUS_W-1:0] status,
                                       logic [SLOT_W-1:0] slot, logic found,
                                       logic [TIME_W-1:0] left);
    timer_result_t r;
    r.status = status;
    r.slot   = slot;
    r.found  = found;
    r.left   = left;
    r.last   = 1'b0;
    awaited_results = {awaited_results, r};
  endfunction

  // Time left before a slot is due; a due or overdue slot reads zero.
  function automatic logic [TIME_W-1:0] ticks_remaining(int idx);
    logic [TIME_W-1:0] elapsed;
    elapsed = tick_count - slot_began[idx];
    if (elapsed >= slot_period[idx]) return '0;
    return slot_period[idx] - elapsed;
  endfunction

  // A slot number beyond the bank never holds a live timer.
  function automatic bit slot_in_use(logic [SLOT_W-1:0] s);
    if (s >= NUM_TIMERS) return 1'b0;
    return slot_live[s];
  endfunction

  // Updates the shadow state for one command and queues its results.
  function automatic void predict_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] s,
                                          logic [TIME_W-1:0] delay,
                                          logic [REPS_W-1:0] reps,
                                          logic [TIME_W-1:0] thr);
    int queued_before;
    int free_idx;
    logic [TIME_W-1:0] left;
    queued_before = awaited_results.size();
    case (op)
      OP_TICK: begin
        tick_count = tick_count + TIME_W'(1);
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (slot_live[i] && (tick_count - slot_began[i]) >= slot_period[i]) begin
            await_result(ST_FIRED, SLOT_W'(i), 1'b0, '0);
            if (slot_reps_left[i] == REPS_W'(1)) begin
              slot_live[i] = 1'b0;
            end else begin
              if (slot_reps_left[i] != '0) begin
                slot_reps_left[i] = slot_reps_left[i] - REPS_W'(1);
              end
              slot_began[i] = tick_count;
            end
          end
        end
      end
      OP_ADD: begin
        free_idx = -1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!slot_live[i] && free_idx < 0) free_idx = i;
        end
        if (delay < TIME_W'(shortest_delay)) begin
          await_result(ST_SHORT, '0, 1'b0, '0);
        end else if (free_idx < 0) begin
          await_result(ST_FULL, '0, 1'b0, '0);
        end else begin
          slot_live[free_idx]      = 1'b1;
          slot_began[free_idx]     = tick_count;
          slot_period[free_idx]    = delay;
          slot_reps_left[free_idx] = reps;
          await_result(ST_OK, SLOT_W'(free_idx), 1'b0, '0);
        end
      end
      OP_REMOVE, OP_RESET: begin
        if (!slot_in_use(s)) begin
          await_result(ST_NOTIMER, s, 1'b0, '0);
        end else begin
          if (op == OP_REMOVE) slot_live[s] = 1'b0;
          else slot_began[s] = tick_count;
          await_result(ST_OK, s, 1'b0, '0);
        end
      end
      OP_EXISTS: begin
        await_result(ST_OK, s, slot_in_use(s), '0);
      end
      OP_LIST: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (slot_live[i]) begin
            left = ticks_remaining(i);
            if (thr == '0 || left <= thr) await_result(ST_LISTED, SLOT_W'(i), 1'b0, left);
          end
        end
      end
      default: begin
      end
    endcase
    if (awaited_results.size() == queued_before) await_result(ST_NOTHING, '0, 1'b0, '0);
    awaited_results[awaited_results.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                      logic [TIME_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_total++;
    end
  endfunction

  // All ports are sampled at the rising edge, before any of them change.
  always @(posedge clk) begin : watch
    timer_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        slot_live[i]      = 1'b0;
        slot_began[i]     = '0;
        slot_period[i]    = '0;
        slot_reps_left[i] = '0;
      end
      tick_count     = '0;
      shortest_delay = MIN_INTERVAL_RST;
      awaited_results.delete();
    end else begin
      // Result transaction: compare with the oldest awaited result.
      if (out_valid === 1'b1) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                   $time, out_status, out_timer_slot);
          mismatch_total++;
        end else begin
          want = awaited_results.pop_front();
          checked_total++;
          if (want.status == ST_FIRED) fire_total++;
          check_field("status", TIME_W'(want.status), TIME_W'(out_status));
          check_field("timer_slot", TIME_W'(want.slot), TIME_W'(out_timer_slot));
          check_field("found", TIME_W'(want.found), TIME_W'(out_found));
          check_field("time_left", want.left, out_time_left);
          check_field("last", TIME_W'(want.last), TIME_W'(out_last));
        end
      end
      if (cfg_we === 1'b1) shortest_delay = cfg_wdata;
      // Command transaction accepted at this edge.
      if (start === 1'b1 && busy === 1'b0) begin
        predict_command(in_opcode, in_slot, in_delay_ticks, in_repeat_count, in_threshold);
      end
    end
    mismatches      <= mismatch_total;
    pending         <= awaited_results.size();
    results_checked <= checked_total;
    fires_seen      <= fire_total;
  end

endmodule

[bench/repeating_timer_bank_test.sv]
// ----------------------------------------------------------------------------
// Repeating timer bank testbench
// Drives directed corner cases and then random command traffic, with
// bank-filling bursts and sender gaps, through several minimum delay
// settings. A separate checker predicts and compares; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module repeating_timer_bank_test;

  timeunit 1ns;
  timeprecision 1ps;

  import rtb_pkg::*;

  localparam int unsigned NUM_TIMERS   = 16;
  localparam int          RANDOM_ITEMS = 410;
  localparam int          CYCLE_LIMIT  = 200000;

  // Opcodes that the bank does not use.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                start           = 1'b0;
  logic [OP_W-1:0]     in_opcode       = OP_TICK;
  logic [SLOT_W-1:0]   in_slot         = '0;
  logic [TIME_W-1:0]   in_delay_ticks  = '0;
  logic [REPS_W-1:0]   in_repeat_count = '0;
  logic [TIME_W-1:0]   in_threshold    = '0;
  logic                cfg_we          = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata       = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_timer_slot;
  logic                out_found;
  logic [TIME_W-1:0]   out_time_left;
  logic                out_last;

  int mismatches;
  int pending;
  int results_checked;
  int fires_seen;

  int               cycle_count   = 0;
  int               commands_sent = 0;
  int               settings_used = 0;
  int               idle_pct      = 27;
  logic [CFG_W-1:0] min_setting   = MIN_INTERVAL_RST;

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  repeating_timer_bank #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_slot        (in_slot),
    .in_delay_ticks (in_delay_ticks),
    .in_repeat_count(in_repeat_count),
    .in_threshold   (in_threshold),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_timer_slot (out_timer_slot),
    .out_found      (out_found),
    .out_time_left  (out_time_left),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  timer_bank_checker #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_slot        (in_slot),
    .in_delay_ticks (in_delay_ticks),
    .in_repeat_count(in_repeat_count),
    .in_threshold   (in_threshold),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_timer_slot (out_timer_slot),
    .out_found      (out_found),
    .out_time_left  (out_time_left),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .pending        (pending),
    .results_checked(results_checked),
    .fires_seen     (fires_seen)
  );

  // One command transaction, after an optional random gap with start held
  // low, so that the sender is not always ready.
  task automatic issue_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] s,
                               logic [TIME_W-1:0] delay, logic [REPS_W-1:0] reps,
                               logic [TIME_W-1:0] thr);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 24);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_slot         <= s;
    in_delay_ticks  <= delay;
    in_repeat_count <= reps;
    in_threshold    <= thr;
    do @(posedge clk); while (busy !== 1'b0);
    commands_sent++;
  endtask

  // Holds off until the bank is idle and every awaited result has arrived.
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy !== 1'b0);
  endtask

  task automatic write_min_interval(logic [CFG_W-1:0] value);
    wait_for_drain();
    cfg_we      <= 1'b1;
    cfg_wdata   <= value;
    min_setting = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Fills every slot, tries one add too many and lists the whole bank.
  task automatic fill_bank();
    repeat (NUM_TIMERS + 1) begin
      issue_command(OP_ADD, SLOT_W'($urandom_range(0, 63)),
                    TIME_W'(min_setting) + TIME_W'($urandom_range(0, 12)),
                    REPS_W'($urandom_range(1, 4)), TIME_W'($urandom()));
    end
    issue_command(OP_LIST, SLOT_W'($urandom_range(0, 63)), TIME_W'($urandom()),
                  REPS_W'($urandom()), '0);
  endtask

  // A random command: every field starts fully random, then the fields that
  // the opcode uses are steered towards values that keep timers firing.
  task automatic random_command();
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] s;
    logic [TIME_W-1:0] d;
    logic [REPS_W-1:0] r;
    logic [TIME_W-1:0] t;
    int                pick;
    s    = SLOT_W'($urandom_range(0, 63));
    d    = TIME_W'($urandom());
    r    = REPS_W'($urandom_range(0, 65535));
    t    = TIME_W'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_TICK;
    else if (pick < 65) op = OP_ADD;
    else if (pick < 72) op = OP_REMOVE;
    else if (pick < 79) op = OP_RESET;
    else if (pick < 86) op = OP_EXISTS;
    else if (pick < 96) op = OP_LIST;
    else if (pick < 98) op = OP_SPARE_A;
    else op = OP_SPARE_B;
    if ($urandom_range(0, 3) != 0) s = SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
    pick = $urandom_range(0, 9);
    if (pick < 7) d = TIME_W'(min_setting) + TIME_W'($urandom_range(0, 12));
    else if (pick == 7 && min_setting > 0) d = TIME_W'(min_setting) - TIME_W'(1);
    if ($urandom_range(0, 9) < 8) r = REPS_W'($urandom_range(0, 4));
    pick = $urandom_range(0, 9);
    if (pick < 3) t = '0;
    else if (pick < 8) t = TIME_W'($urandom_range(0, 16));
    issue_command(op, s, d, r, t);
  endtask

  // The run is ended here if the bank stops answering.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, pending);
    $display("repeating_timer_bank verification failed");
    $finish;
  end

  initial begin : stimulus
    int directed_count;
    int target;
    int done;
    logic [CFG_W-1:0] setting;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first with the reset minimum delay of 50.
    issue_command(OP_TICK, '0, '0, '0, '0);               // nothing due
    issue_command(OP_LIST, '0, '0, '0, '0);               // empty list
    issue_command(OP_ADD, '0, 32'd49, 16'd1, '0);         // one below minimum
    issue_command(OP_ADD, '0, 32'd50, 16'd1, '0);         // exactly minimum
    issue_command(OP_ADD, '1, '1, '1, '1);                // largest delay and count
    issue_command(OP_EXISTS, 6'd0, '0, '0, '0);
    issue_command(OP_EXISTS, 6'd63, '0, '0, '0);          // beyond the bank
    issue_command(OP_REMOVE, 6'd63, '0, '0, '0);
    issue_command(OP_RESET, 6'd2, '0, '0, '0);            // free slot
    issue_command(OP_LIST, '0, '0, '0, '1);
    issue_command(OP_LIST, '0, '0, '0, 32'd50);           // threshold on the edge
    issue_command(OP_SPARE_A, '1, '1, '1, '1);
    issue_command(OP_SPARE_B, '0, '0, '0, '0);
    issue_command(OP_RESET, 6'd0, '0, '0, '0);
    issue_command(OP_REMOVE, 6'd1, '0, '0, '0);
    issue_command(OP_REMOVE, 6'd1, '0, '0, '0);           // already freed

    // Zero minimum: a zero delay timer is due at once and fires every tick.
    write_min_interval('0);
    issue_command(OP_ADD, '0, '0, 16'd3, '0);
    issue_command(OP_LIST, '0, '0, '0, 32'd1);            // due timer reads zero
    repeat (3) issue_command(OP_TICK, '0, '0, '0, '0);    // last repeat frees it
    issue_command(OP_ADD, '0, '0, '0, '0);                // repeats forever
    repeat (2) issue_command(OP_TICK, '0, '0, '0, '0);
    issue_command(OP_REMOVE, 6'd1, '0, '0, '0);
    directed_count = commands_sent;

    // Random part in five settings of the minimum delay.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       setting = 16'd1;
        1:       setting = '1;
        2:       setting = 16'd3;
        3:       setting = CFG_W'($urandom_range(2, 9));
        default: setting = '0;
      endcase
      write_min_interval(setting);
      target = directed_count + RANDOM_ITEMS * (p + 1) / 5;
      while (commands_sent < target) begin
        done = commands_sent - directed_count;
        if (done < RANDOM_ITEMS / 3) idle_pct = 27;
        else if (done < 2 * RANDOM_ITEMS / 3) idle_pct = 71;
        else idle_pct = 0;
        if ($urandom_range(0, 39) == 0) fill_bank();
        else random_command();
      end
    end

    wait_for_drain();
    repeat (NUM_TIMERS + 8) @(posedge clk);

    $display("Covered %0d commands over %0d minimum delay settings.",
             commands_sent, settings_used);
    $display("Checked %0d results, %0d of them timer fires.", results_checked, fires_seen);
    if (mismatches == 0) begin
      $display("repeating_timer_bank verification clean");
    end else begin
      $display("repeating_timer_bank verification failed");
    end
    $finish;
  end

endmodule
